[design/hum_lin_pkg.sv]
`default_nettype none

package hum_lin_pkg;

    localparam int SAMPLE_W     = 10;
    localparam int HUM_W        = 10;
    localparam int STATUS_W     = 2;
    localparam int TABLE_POINTS = 21;
    localparam int K_W          = $clog2(TABLE_POINTS);
    localparam int SPAN_W       = 6;
    localparam int NUM_W        = 12;
    localparam int CNT_W        = $clog2(NUM_W);

    localparam logic [K_W-1:0]      LAST_IDX    = K_W'(TABLE_POINTS - 1);
    localparam logic [SAMPLE_W-1:0] CAL_FIRST   = SAMPLE_W'(236);
    localparam logic [SAMPLE_W-1:0] CAL_LAST    = SAMPLE_W'(835);
    localparam logic [SAMPLE_W-1:0] OPEN_LIMIT  = SAMPLE_W'(236 / 2);
    localparam logic [HUM_W-1:0]    STEP_TENTHS = HUM_W'(50);
    localparam logic [HUM_W-1:0]    FULL_MARK   = HUM_W'(1001);
    localparam logic [HUM_W-1:0]    LOW_MARK    = HUM_W'(1);
    localparam logic [HUM_W-1:0]    OPEN_MARK   = HUM_W'(0);

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_INTERP = 2'd0;
    localparam status_t STATUS_OPEN   = 2'd1;
    localparam status_t STATUS_LOW    = 2'd2;
    localparam status_t STATUS_HIGH   = 2'd3;

    // calibration points, one every 5 percent
    function automatic logic [SAMPLE_W-1:0] cal_point(input logic [K_W-1:0] idx);
        logic [SAMPLE_W-1:0] pt;
        unique case (idx)
            5'd0:    pt = SAMPLE_W'(236);
            5'd1:    pt = SAMPLE_W'(267);
            5'd2:    pt = SAMPLE_W'(299);
            5'd3:    pt = SAMPLE_W'(330);
            5'd4:    pt = SAMPLE_W'(360);
            5'd5:    pt = SAMPLE_W'(391);
            5'd6:    pt = SAMPLE_W'(419);
            5'd7:    pt = SAMPLE_W'(448);
            5'd8:    pt = SAMPLE_W'(475);
            5'd9:    pt = SAMPLE_W'(503);
            5'd10:   pt = SAMPLE_W'(532);
            5'd11:   pt = SAMPLE_W'(559);
            5'd12:   pt = SAMPLE_W'(587);
            5'd13:   pt = SAMPLE_W'(615);
            5'd14:   pt = SAMPLE_W'(644);
            5'd15:   pt = SAMPLE_W'(673);
            5'd16:   pt = SAMPLE_W'(704);
            5'd17:   pt = SAMPLE_W'(735);
            5'd18:   pt = SAMPLE_W'(767);
            5'd19:   pt = SAMPLE_W'(801);
            5'd20:   pt = SAMPLE_W'(835);
            default: pt = SAMPLE_W'(835);
        endcase
        return pt;
    endfunction

endpackage

`default_nettype wire

[design/humidity_table_linearizer.sv]
// sequence: out-of-table samples go from request accept through classify and finish to result valid;
// interpolated samples also pass a table walk of 1 to 20 steps and a 12-step divider
// flow: one request at a time; the next is taken once the sequencer is idle again
// the result register frees the sequencer while a finished result waits downstream
// reset: asynchronous active-low rst_n clears the sequencer and result valid
`default_nettype none

module humidity_table_linearizer
    import hum_lin_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                sample_valid,
    output      logic                sample_ready,
    input  wire logic [SAMPLE_W-1:0] raw_sample,
    output      logic                result_valid,
    input  wire logic                result_ready,
    output      logic [HUM_W-1:0]    humidity_tenths,
    output      status_t             range_status
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CLASSIFY = 3'd1;
    localparam logic [2:0] ST_SEARCH   = 3'd2;
    localparam logic [2:0] ST_DIVIDE   = 3'd3;
    localparam logic [2:0] ST_FINISH   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [SAMPLE_W-1:0] s_reg, s_next;
    logic [K_W-1:0]      k_reg, k_next;
    logic [SPAN_W-1:0]   span_reg, span_next;
    logic [SPAN_W-1:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [HUM_W-1:0]    base_reg, base_next;
    status_t             status_reg, status_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                result_valid_reg, result_valid_next;
    logic [HUM_W-1:0]    hum_out_reg, hum_out_next;
    status_t             status_out_reg, status_out_next;

    logic [SAMPLE_W-1:0] pt_hi;
    logic [SAMPLE_W-1:0] pt_lo;
    logic [SAMPLE_W-1:0] off_full;
    logic [SAMPLE_W-1:0] span_full;
    logic [SPAN_W:0]     trial;
    logic                take;
    logic                out_free;

    assign pt_hi     = cal_point(k_reg);
    assign pt_lo     = cal_point(k_reg - K_W'(1));
    assign off_full  = s_reg - pt_lo;
    assign span_full = pt_hi - pt_lo;
    assign trial     = {rem_reg, num_reg[NUM_W-1]};
    assign take      = trial >= {1'b0, span_reg};
    assign out_free  = !result_valid_reg || result_ready;

    always_comb
    begin
        state_next        = state_reg;
        s_next            = s_reg;
        k_next            = k_reg;
        span_next         = span_reg;
        rem_next          = rem_reg;
        num_next          = num_reg;
        base_next         = base_reg;
        status_next       = status_reg;
        cnt_next          = cnt_reg;
        hum_out_next      = hum_out_reg;
        status_out_next   = status_out_reg;
        result_valid_next = result_valid_reg && !result_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    s_next     = raw_sample;
                    k_next     = K_W'(1);
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                num_next   = '0;
                state_next = ST_FINISH;
                if (s_reg <= OPEN_LIMIT)
                begin
                    base_next   = OPEN_MARK;
                    status_next = STATUS_OPEN;
                end
                else if (s_reg <= CAL_FIRST)
                begin
                    base_next   = LOW_MARK;
                    status_next = STATUS_LOW;
                end
                else if (s_reg >= CAL_LAST)
                begin
                    base_next   = FULL_MARK;
                    status_next = STATUS_HIGH;
                end
                else
                begin
                    status_next = STATUS_INTERP;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (k_reg < LAST_IDX && s_reg >= pt_hi)
                begin
                    k_next = k_reg + K_W'(1);
                end
                else
                begin
                    span_next  = span_full[SPAN_W-1:0];
                    num_next   = NUM_W'(off_full[SPAN_W-1:0]) * NUM_W'(STEP_TENTHS);
                    base_next  = HUM_W'(k_reg - K_W'(1)) * STEP_TENTHS;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                // restoring divide, one quotient bit per cycle
                rem_next = take ? SPAN_W'(trial - {1'b0, span_reg}) : trial[SPAN_W-1:0];
                num_next = {num_reg[NUM_W-2:0], take};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    hum_out_next      = base_reg + num_reg[HUM_W-1:0];
                    status_out_next   = status_reg;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg          <= s_next;
        k_reg          <= k_next;
        span_reg       <= span_next;
        rem_reg        <= rem_next;
        num_reg        <= num_next;
        base_reg       <= base_next;
        status_reg     <= status_next;
        cnt_reg        <= cnt_next;
        hum_out_reg    <= hum_out_next;
        status_out_reg <= status_out_next;
    end

    assign sample_ready    = (state_reg == ST_IDLE);
    assign result_valid    = result_valid_reg;
    assign humidity_tenths = hum_out_reg;
    assign range_status    = status_out_reg;

endmodule

`default_nettype wire

[design/hum_lin_checker.sv]
`default_nettype none

module hum_lin_checker
    import hum_lin_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                sample_valid,
    input wire logic                sample_ready,
    input wire logic [SAMPLE_W-1:0] raw_sample,
    input wire logic                result_valid,
    input wire logic                result_ready,
    input wire logic [HUM_W-1:0]    humidity_tenths,
    input wire status_t             range_status
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("request taken while a sample is still in work");

    a_marker_values: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (range_status == STATUS_OPEN && humidity_tenths == OPEN_MARK)
            || (range_status == STATUS_LOW && humidity_tenths == LOW_MARK)
            || (range_status == STATUS_HIGH && humidity_tenths == FULL_MARK)
            || (range_status == STATUS_INTERP && humidity_tenths < HUM_W'(1000)))
        else $error("result value does not match its range status");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(humidity_tenths) && $stable(range_status))
        else $error("stalled result changed");

    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready && !result_valid |=> !result_valid)
        else $error("result appeared too early");

endmodule

bind humidity_table_linearizer hum_lin_checker u_hum_lin_checker (.*);

`default_nettype wire
